FILE: rtl/wzn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wzn_pkg
// Shared types and constants for the windowed z-score normaliser.
// ---------------------------------------------------------------------------
package wzn_pkg;

  localparam int DefWindowDepth = 1024;
  localparam int SampleW        = 24;
  localparam int SumW           = 34;
  localparam int SqW            = 58;
  localparam int DivW           = 64;
  localparam logic [23:0] ScaleReset = 24'd65536;
  localparam logic [5:0]  EpsilonQ32 = 6'd43;
  localparam int QueueDepth     = 2;

  typedef struct packed {
    logic signed [23:0] potential_sample;
    logic signed [23:0] companion_value;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] normalized_sample;
    logic signed [23:0] companion_out;
  } out_item_t;

  // Work handed from the front end to the arithmetic back end
  typedef struct packed {
    logic signed [23:0] sample;
    logic signed [23:0] companion;
    logic signed [33:0] sum;
    logic [57:0]        sum_sq;
    logic [10:0]        count;
  } job_t;

endpackage : wzn_pkg
`default_nettype wire

FILE: rtl/wzn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wzn_front
// Accepts items, updates the sample ring and the running sums, emits a job.
// ---------------------------------------------------------------------------
module wzn_front
  import wzn_pkg::*;
#(
  parameter int WINDOW_DEPTH = DefWindowDepth
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  in_item,
  input  wire logic      in_valid,
  output logic           in_ready,
  output job_t           job,
  output logic           job_valid,
  input  wire logic      job_ready
);

  localparam int PtrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic signed [23:0] ring [WINDOW_DEPTH];
  logic signed [23:0] old_sample;
  logic [1:0]         state;
  logic [PtrW-1:0]    write_pointer;
  logic [10:0]        filled_count;
  logic signed [33:0] window_sum;
  logic [57:0]        window_sum_squares;
  in_item_t           held;
  logic               full_window;
  logic signed [47:0] sq_new;
  logic signed [47:0] sq_old;

  assign full_window = (filled_count == 11'(WINDOW_DEPTH));
  assign in_ready    = (state == S_IDLE);
  assign job_valid   = (state == S_OUT);
  assign sq_new      = held.potential_sample * held.potential_sample;
  assign sq_old      = old_sample * old_sample;

  // Ring memory: read the evicted entry, then write the new one
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      old_sample <= ring[write_pointer];
    end
    if (state == S_UPD) begin
      ring[write_pointer] <= held.potential_sample;
    end
  end

  // Sequence one item through read, update and hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      write_pointer      <= '0;
      filled_count       <= '0;
      window_sum         <= '0;
      window_sum_squares <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            held  <= in_item;
            state <= S_READ;
          end
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          if (full_window) begin
            window_sum <= window_sum - 34'(old_sample) + 34'(held.potential_sample);
            window_sum_squares <= window_sum_squares - 58'(unsigned'(sq_old))
                                  + 58'(unsigned'(sq_new));
          end else begin
            window_sum <= window_sum + 34'(held.potential_sample);
            window_sum_squares <= window_sum_squares + 58'(unsigned'(sq_new));
            filled_count <= filled_count + 11'd1;
          end
          write_pointer <= (write_pointer == PtrW'(WINDOW_DEPTH - 1)) ? '0
                           : write_pointer + PtrW'(1);
          state <= S_OUT;
        end
        S_OUT: begin
          if (job_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign job.sample    = held.potential_sample;
  assign job.companion = held.companion_value;
  assign job.sum       = window_sum;
  assign job.sum_sq    = window_sum_squares;
  assign job.count     = filled_count;

endmodule : wzn_front
`default_nettype wire

FILE: rtl/wzn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wzn_queue
// Short job queue decoupling the front end from the back end.
// ---------------------------------------------------------------------------
module wzn_queue
  import wzn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t wr_data,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output job_t      rd_data,
  output logic      rd_valid,
  input  wire logic rd_ready
);

  job_t       slots [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (fill != 2'(QueueDepth));
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Store jobs
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule : wzn_queue
`default_nettype wire

FILE: rtl/wzn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wzn_back
// Mean, variance, square root and final division, one shared bit-serial
// divider and a two-bit-per-step square root; result held in an output slot.
// ---------------------------------------------------------------------------
module wzn_back
  import wzn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [23:0] output_scale,
  input  wire job_t       job,
  input  wire logic       job_valid,
  output logic            job_ready,
  output out_item_t       out_item,
  output logic            out_valid,
  input  wire logic       out_ready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MEAN  = 4'd1;
  localparam logic [3:0] S_MSQ   = 4'd2;
  localparam logic [3:0] S_SQDIV = 4'd3;
  localparam logic [3:0] S_VAR   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_PROD  = 4'd6;
  localparam logic [3:0] S_FDIV  = 4'd7;
  localparam logic [3:0] S_SAT   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_FLOAD = 4'd10;

  logic [3:0]          state;
  job_t                cur;
  logic [23:0]         scale;
  // shared restoring divider
  logic [63:0]         dq;
  logic [63:0]         drem;
  logic [63:0]         dden;
  logic [6:0]          dcnt;
  logic                dneg;
  logic [64:0]         trial;
  // values
  logic signed [33:0]  mean;
  logic signed [24:0]  mean_n;
  logic signed [49:0]  mean_sq;
  logic signed [63:0]  msq;
  logic signed [63:0]  var_q;
  logic [63:0]         sq_v;
  logic [63:0]         sq_res;
  logic [63:0]         sq_bit;
  logic [63:0]         sq_sum;
  logic signed [63:0]  prod;
  logic signed [49:0]  prod_w;
  logic signed [24:0]  diff;
  logic signed [63:0]  res;

  assign trial     = {drem[62:0], dq[63]} - {1'b0, dden};
  assign sq_sum    = sq_res + sq_bit;
  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  // the mean and the difference both fit 25 signed bits
  assign mean_n    = 25'(mean);
  assign mean_sq   = mean_n * mean_n;
  assign diff      = 25'(cur.sample) - 25'(mean);
  assign prod_w    = diff * $signed({1'b0, scale});

  // Sequence the arithmetic for one job
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            scale <= output_scale;
            // mean = sum / count, magnitude division
            dneg  <= job.sum[33];
            dq    <= job.sum[33] ? -64'(job.sum) : 64'(job.sum);
            drem  <= '0;
            dden  <= 64'(job.count);
            dcnt  <= 7'd64;
            state <= S_MEAN;
          end
        end
        S_MEAN, S_SQDIV, S_FDIV: begin
          // one quotient bit a cycle
          if (dcnt != 7'd0) begin
            if (!trial[64]) begin
              drem <= trial[63:0];
              dq   <= {dq[62:0], 1'b1};
            end else begin
              drem <= {drem[62:0], dq[63]};
              dq   <= {dq[62:0], 1'b0};
            end
            dcnt <= dcnt - 7'd1;
          end else if (state == S_MEAN) begin
            mean  <= dneg ? -34'(dq) : 34'(dq);
            state <= S_MSQ;
          end else if (state == S_SQDIV) begin
            var_q <= $signed(dq) - msq;
            state <= S_VAR;
          end else begin
            res   <= dneg ? -$signed(dq) : $signed(dq);
            state <= S_SAT;
          end
        end
        S_MSQ: begin
          msq   <= 64'(mean_sq);
          dq    <= 64'(cur.sum_sq);
          drem  <= '0;
          dden  <= 64'(cur.count);
          dcnt  <= 7'd64;
          state <= S_SQDIV;
        end
        S_VAR: begin
          sq_v   <= (var_q[63] ? 64'd0 : var_q) + 64'(EpsilonQ32);
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit a cycle
          if (sq_bit != 64'd0) begin
            if (sq_v >= sq_sum) begin
              sq_v   <= sq_v - sq_sum;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          prod  <= 64'(prod_w);
          state <= S_FLOAD;
        end
        S_FLOAD: begin
          dneg  <= prod[63];
          dq    <= prod[63] ? 64'(-prod) : 64'(prod);
          drem  <= '0;
          dden  <= sq_res;
          dcnt  <= 7'd64;
          state <= S_FDIV;
        end
        S_SAT: begin
          if (res > 64'sd8388607) cur.sample <= 24'sh7fffff;
          else if (res < -64'sd8388608) cur.sample <= -24'sh800000;
          else cur.sample <= res[23:0];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_item.normalized_sample = cur.sample;
  assign out_item.companion_out     = cur.companion;

endmodule : wzn_back
`default_nettype wire

FILE: rtl/windowed_zscore_normalizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// windowed_zscore_normalizer_top
// Sliding-window z-score normaliser for signed Q8.16 samples.
// ---------------------------------------------------------------------------
// Input queue side: push an item while full is low; sample and companion.
// Result queue side: the result is shown while empty is low, taken by pop.
// The user must write output_scale through cfg_we / cfg_data only while the
// block is idle; the block itself does not enforce this. An accepted item
// passes through the front end and the job queue, three 64-step bit-serial
// divides (mean, mean square, final quotient), a 32-step square root and the
// load, product and saturation steps between them.
// The back end takes no new job until its result has been popped, which sets
// the throughput; the front end also handles one item at a time.
// Up to four items are held: one in the back end, two in the job queue and
// one in the front end. Reset clears the window, the sums and sets
// output_scale to 1.0.
// If pop stays low the result holds, the back end stalls, the job queue
// fills and then full rises; nothing is lost.
// ---------------------------------------------------------------------------
module windowed_zscore_normalizer_top
  import wzn_pkg::*;
#(
  parameter int WINDOW_DEPTH = DefWindowDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_item_t    in_item,
  input  wire logic        push,
  output logic             full,
  output out_item_t        out_item,
  output logic             empty,
  input  wire logic        pop,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_data
);

  logic [23:0] output_scale;
  logic        in_ready;
  logic        out_valid;
  job_t        fjob;
  logic        fjob_valid;
  logic        fjob_ready;
  job_t        bjob;
  logic        bjob_valid;
  logic        bjob_ready;

  // Hold the gain register
  always_ff @(posedge clk) begin
    if (rst) output_scale <= ScaleReset;
    else if (cfg_we) output_scale <= cfg_data;
  end

  assign full  = !in_ready;
  assign empty = !out_valid;

  wzn_front #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_front (
    .clk, .rst, .in_item, .in_valid(push), .in_ready,
    .job(fjob), .job_valid(fjob_valid), .job_ready(fjob_ready)
  );

  wzn_queue u_queue (
    .clk, .rst, .wr_data(fjob), .wr_valid(fjob_valid), .wr_ready(fjob_ready),
    .rd_data(bjob), .rd_valid(bjob_valid), .rd_ready(bjob_ready)
  );

  wzn_back u_back (
    .clk, .rst, .output_scale, .job(bjob), .job_valid(bjob_valid),
    .job_ready(bjob_ready), .out_item, .out_valid, .out_ready(pop)
  );

endmodule : windowed_zscore_normalizer_top
`default_nettype wire
